### rtl/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiplier
// Sizes, command and register codes, word structs and the control link
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  // sizes
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int POS_W      = 3;
  localparam int CMD_W      = 2;
  localparam int PRODUCT_W  = 32;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int ACC_W      = PROD_W + IDX_W + 1;
  localparam int LIM_EXP    = (ACC_W - 2 < 61) ? ACC_W - 2 : 61;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic [POS_W-1:0]             row_index;
    logic [POS_W-1:0]             col_index;
    logic signed [ELEM_WIDTH-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product;
    logic [POS_W-1:0]            out_row;
    logic [POS_W-1:0]            out_col;
    logic                        last;
    logic                        mismatch;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic              issue;
    logic              emit_mis;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              first;
    logic              fin;
    logic              last;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } mm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CFG_W-1:0] m;
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] p;
    logic             mismatch;
    logic             pipe_busy;
  } mm_stat_t;

  // register value to usable dimension
  function automatic logic [CFG_W-1:0] dim_of(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] d;
    d = v;
    if (d == '0) d = CFG_W'(1);
    if ({1'b0, d} > (CFG_W + 1)'(MAX_DIM)) d = CFG_W'(MAX_DIM);
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/mm_ram.sv
// ----------------------------------------------------------------------------
// mm_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl: sequencer of the matrix multiplier
// Walks i, j and k over the product and issues one multiply-accumulate
// a cycle, then waits for the datapath pipeline to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_cmd,
  input  wire mm_pkg::mm_stat_t  stat,
  output logic                   busy,
  output mm_pkg::mm_cmd_t        ctl
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             k_end, j_end, i_end, accept_cmp;

  assign busy       = (state_r != ST_IDLE);
  assign accept_cmp = start && !busy && (in_cmd == CMD_COMPUTE);

  // loop ends
  assign k_end = (CFG_W'(k_r) == stat.n - CFG_W'(1));
  assign j_end = (CFG_W'(j_r) == stat.p - CFG_W'(1));
  assign i_end = (CFG_W'(i_r) == stat.m - CFG_W'(1));

  // command to datapath
  always_comb begin
    ctl          = '0;
    ctl.issue    = (state_r == ST_RUN);
    ctl.emit_mis = accept_cmp && stat.mismatch;
    ctl.a_addr   = {i_r, k_r};
    ctl.b_addr   = {k_r, j_r};
    ctl.first    = (k_r == '0);
    ctl.fin      = k_end;
    ctl.last     = k_end && j_end && i_end;
    ctl.row      = POS_W'(i_r);
    ctl.col      = POS_W'(j_r);
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_cmp && !stat.mismatch) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_nxt = k_r + IDX_W'(1);
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + IDX_W'(1);
          end else begin
            j_nxt = '0;
            if (!i_end) i_nxt = i_r + IDX_W'(1);
            else        state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

endmodule

`default_nettype wire

### rtl/mm_dp.sv
// ----------------------------------------------------------------------------
// mm_dp: datapath of the matrix multiplier
// Dimension registers, the two element stores, a pipelined
// multiply-accumulate unit and the saturating output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load_acc,
  input  wire mm_pkg::in_word_t                  in_word,
  input  wire logic                              cfg_we,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mm_pkg::CFG_W-1:0]          cfg_data,
  input  wire mm_pkg::mm_cmd_t                   ctl,
  output mm_pkg::mm_stat_t                       stat,
  output logic                                   out_valid,
  output mm_pkg::out_word_t                      out_word
);
  import mm_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_LIM  = ACC_W'(1) << LIM_EXP;
  localparam logic signed [ACC_W-1:0] OUT_MAX  =
    {{(ACC_W-PRODUCT_W){1'b0}}, 1'b0, {(PRODUCT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN  =
    {{(ACC_W-PRODUCT_W){1'b1}}, 1'b1, {(PRODUCT_W-1){1'b0}}};

  logic [CFG_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  logic                  in_range, we_a, we_b;
  logic [ADDR_W-1:0]     waddr;
  logic [ELEM_WIDTH-1:0] a_rd, b_rd;

  // pipeline tags
  logic                      v1_r, first1_r, fin1_r, last1_r;
  logic [POS_W-1:0]          row1_r, col1_r;
  logic                      v2_r, first2_r, fin2_r, last2_r;
  logic [POS_W-1:0]          row2_r, col2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      v3_r, last3_r;
  logic [POS_W-1:0]          row3_r, col3_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_base, acc_sum;
  logic signed [PRODUCT_W-1:0] sat;

  logic      out_valid_r;
  out_word_t out_word_r;

  // dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_data;
        REG_A_COLS: a_cols_r <= cfg_data;
        REG_B_ROWS: b_rows_r <= cfg_data;
        REG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // status to controller
  always_comb begin
    stat.m         = dim_of(a_rows_r);
    stat.n         = dim_of(a_cols_r);
    stat.p         = dim_of(b_cols_r);
    stat.mismatch  = (dim_of(a_cols_r) != dim_of(b_rows_r));
    stat.pipe_busy = v1_r || v2_r || v3_r;
  end

  // element loads
  assign in_range = ({1'b0, in_word.row_index} < (POS_W + 1)'(MAX_DIM)) &&
                    ({1'b0, in_word.col_index} < (POS_W + 1)'(MAX_DIM));
  assign waddr = {in_word.row_index[IDX_W-1:0], in_word.col_index[IDX_W-1:0]};
  assign we_a  = load_acc && in_range && (in_word.cmd == CMD_LOAD_A);
  assign we_b  = load_acc && in_range && (in_word.cmd == CMD_LOAD_B);

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_word.element),
    .raddr (ctl.a_addr),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_word.element),
    .raddr (ctl.b_addr),
    .rdata (b_rd)
  );

  // accumulate with wide clamp
  always_comb begin
    acc_base = first2_r ? '0 : acc_r;
    acc_sum  = acc_base + ACC_W'(prod_r);
    acc_nxt  = acc_sum;
    if (acc_sum > ACC_LIM)  acc_nxt = ACC_LIM;
    if (acc_sum < -ACC_LIM) acc_nxt = -ACC_LIM;
  end

  // saturate to the result width
  always_comb begin
    if (acc_r > OUT_MAX)      sat = OUT_MAX[PRODUCT_W-1:0];
    else if (acc_r < OUT_MIN) sat = OUT_MIN[PRODUCT_W-1:0];
    else                      sat = acc_r[PRODUCT_W-1:0];
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= ctl.issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r && fin2_r;
      out_valid_r <= ctl.emit_mis || v3_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    first1_r <= ctl.first;
    fin1_r   <= ctl.fin;
    last1_r  <= ctl.last;
    row1_r   <= ctl.row;
    col1_r   <= ctl.col;

    prod_r   <= $signed(a_rd) * $signed(b_rd);
    first2_r <= first1_r;
    fin2_r   <= fin1_r;
    last2_r  <= last1_r;
    row2_r   <= row1_r;
    col2_r   <= col1_r;

    if (v2_r) acc_r <= acc_nxt;
    last3_r <= last2_r;
    row3_r  <= row2_r;
    col3_r  <= col2_r;

    if (ctl.emit_mis) begin
      out_word_r.product  <= '0;
      out_word_r.out_row  <= '0;
      out_word_r.out_col  <= '0;
      out_word_r.last     <= 1'b1;
      out_word_r.mismatch <= 1'b1;
    end else begin
      out_word_r.product  <= sat;
      out_word_r.out_row  <= row3_r;
      out_word_r.out_col  <= col3_r;
      out_word_r.last     <= last3_r;
      out_word_r.mismatch <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### rtl/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply: fixed-point dense matrix multiplier
// Loads A and B element by element, then streams C = A * B in row-major
// order as saturated Q16.16 words.
// ----------------------------------------------------------------------------
// load word: no result, next word may follow at once
// compute word: one multiply-accumulate per cycle through one shared MAC
//   unit reading one A and one B entry a cycle; each result passes the store
//   read, product, accumulator and output registers; busy lasts to the drain
// dimension mismatch: one result the cycle after start, busy stays low
// reset: dimension registers return to 8; the element stores are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire mm_pkg::in_word_t             in_word,
  output logic                              out_valid,
  output mm_pkg::out_word_t                 out_word,
  input  wire logic                         cfg_we,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mm_pkg::CFG_W-1:0]     cfg_data
);
  import mm_pkg::*;

  mm_cmd_t  ctl;
  mm_stat_t stat;
  logic     load_acc;

  assign load_acc = start && !busy;

  mm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_word.cmd),
    .stat   (stat),
    .busy   (busy),
    .ctl    (ctl)
  );

  mm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_acc  (load_acc),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // a mismatch word is always the final word of its run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.mismatch |-> out_word.last)
    else $error("mismatch word without last");

  // a compute word either starts a run or yields a mismatch word
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.cmd == CMD_COMPUTE) |=>
      busy || (out_valid && out_word.mismatch))
    else $error("compute word neither started nor rejected");

  // no word comes directly behind the last product word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last && !out_word.mismatch |=> !out_valid)
    else $error("word after last");

  // inner words only come while a run is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> busy)
    else $error("product word outside a run");

endmodule

`default_nettype wire

### tb/matrix_multiply_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_tb: self-checking bench for the fixed-point matrix multiplier
// Loads A and B through the command port, programs the four dimension
// registers, and checks every C element word against a behavioral
// multiplier kept in the bench, including the mismatch word.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_tb;
  import mm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS   = 96;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_word_t             in_word;
  logic                 out_valid;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // bench copy of the stores and dimension registers
  logic signed [ELEM_WIDTH-1:0] a_mem [MAX_DIM][MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] b_mem [MAX_DIM][MAX_DIM];
  bit                           a_set [MAX_DIM][MAX_DIM];
  bit                           b_set [MAX_DIM][MAX_DIM];
  logic [CFG_W-1:0] reg_a_rows, reg_a_cols, reg_b_rows, reg_b_cols;

  out_word_t c_pending [$];
  int        errors;
  int        words_sent;
  int        computes_sent;
  int        random_words;
  int        results_checked;
  int        mismatch_words;
  bit        no_gaps;

  matrix_multiply DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // register value to the dimension the multiplier actually uses
  function automatic int usable_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // register value for a dimension, sometimes using an out-of-range alias
  function automatic logic [CFG_W-1:0] raw_dim(input int d);
    if (d == 1 && $urandom_range(0, 2) == 0) return '0;
    if (d == MAX_DIM && $urandom_range(0, 2) == 0) return CFG_W'($urandom_range(9, 15));
    return CFG_W'(d);
  endfunction

  function automatic logic signed [ELEM_WIDTH-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_word_t mk_word(input logic [CMD_W-1:0] cmd, input int row,
                                       input int col,
                                       input logic signed [ELEM_WIDTH-1:0] elem);
    in_word_t w;
    w.cmd       = cmd;
    w.row_index = POS_W'(row);
    w.col_index = POS_W'(col);
    w.element   = elem;
    return w;
  endfunction

  function automatic in_word_t compute_word();
    return mk_word(CMD_COMPUTE, int'($urandom_range(0, 7)), int'($urandom_range(0, 7)),
                   ELEM_WIDTH'($urandom));
  endfunction

  // store a load, or queue the C elements a compute command will produce
  function automatic void predict_products(input in_word_t w);
    int        m, n, p;
    longint    acc;
    out_word_t r;
    case (w.cmd)
      CMD_LOAD_A: begin
        a_mem[w.row_index][w.col_index] = w.element;
        a_set[w.row_index][w.col_index] = 1'b1;
      end
      CMD_LOAD_B: begin
        b_mem[w.row_index][w.col_index] = w.element;
        b_set[w.row_index][w.col_index] = 1'b1;
      end
      CMD_COMPUTE: begin
        m = usable_dim(reg_a_rows);
        n = usable_dim(reg_a_cols);
        p = usable_dim(reg_b_cols);
        if (n != usable_dim(reg_b_rows)) begin
          r          = '0;
          r.last     = 1'b1;
          r.mismatch = 1'b1;
          c_pending.push_back(r);
        end else begin
          for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
              acc = 0;
              for (int k = 0; k < n; k++)
                acc += longint'(a_mem[i][k]) * longint'(b_mem[k][j]);
              if (acc > SAT_HI) acc = SAT_HI;
              if (acc < SAT_LO) acc = SAT_LO;
              r.product  = acc[PRODUCT_W-1:0];
              r.out_row  = POS_W'(i);
              r.out_col  = POS_W'(j);
              r.last     = (i == m - 1) && (j == p - 1);
              r.mismatch = 1'b0;
              c_pending.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // one command word, with a random lead-in gap, held until not busy
  task automatic send_word(input in_word_t w);
    int gap;
    int r;
    gap = 0;
    r   = int'($urandom_range(0, 99));
    if (!no_gaps) begin
      if (r >= 90) gap = int'($urandom_range(8, 30));
      else if (r >= 55) gap = int'($urandom_range(1, 3));
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predict_products(w);
    words_sent++;
    if (w.cmd == CMD_COMPUTE) computes_sent++;
  endtask

  // wait until every expected word has come and the block is quiet
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (c_pending.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four dimension registers, one per cycle
  task automatic program_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                              input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
    logic [CFG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idx  [4];
    vals[0] = ar;  idx[0] = REG_A_ROWS;
    vals[1] = ac;  idx[1] = REG_A_COLS;
    vals[2] = br;  idx[2] = REG_B_ROWS;
    vals[3] = bc;  idx[3] = REG_B_COLS;
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= vals[r];
      @(posedge clk);
      case (idx[r])
        REG_A_ROWS: reg_a_rows = vals[r];
        REG_A_COLS: reg_a_cols = vals[r];
        REG_B_ROWS: reg_b_rows = vals[r];
        REG_B_COLS: reg_b_cols = vals[r];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // sums of three full-scale products clip at both ends of the 32-bit range
  task automatic test_saturation();
    program_dims(4'd1, 4'd3, 4'd3, 4'd1);
    for (int k = 0; k < 3; k++) begin
      send_word(mk_word(CMD_LOAD_A, 0, k, 16'sh8000));
      send_word(mk_word(CMD_LOAD_B, k, 0, 16'sh8000));
    end
    send_word(compute_word());
    for (int k = 0; k < 3; k++)
      send_word(mk_word(CMD_LOAD_B, k, 0, 16'sh7fff));
    send_word(compute_word());
  endtask

  // zero and oversized register values, inner dimension at its maximum
  task automatic test_dim_clamp();
    settle();
    program_dims(4'd0, 4'd9, 4'd15, 4'd0);
    for (int k = 3; k < MAX_DIM; k++) begin
      send_word(mk_word(CMD_LOAD_A, 0, k, (k % 2 == 1) ? 16'sh7fff : 16'sh8000));
      send_word(mk_word(CMD_LOAD_B, k, 0, rand_element()));
    end
    send_word(compute_word());
  endtask

  // unused command does nothing, then a compute with unequal inner dimensions
  task automatic test_mismatch_and_unused();
    settle();
    program_dims(4'd0, 4'd0, 4'd12, 4'd1);
    send_word(mk_word(CMD_UNUSED, 7, 7, 16'sh7fff));
    send_word(compute_word());
  endtask

  // load jobs with random content and sizes, each ending in a compute
  task automatic test_random_jobs();
    int       m, n, nb, p, sel, pick;
    in_word_t loads [$];
    in_word_t tmp;
    while (random_words < RANDOM_WORDS) begin
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      sel     = int'($urandom_range(0, 9));
      if (sel == 0) begin
        m = MAX_DIM;
        p = MAX_DIM;
        n = int'($urandom_range(1, 2));
      end else begin
        m = int'($urandom_range(1, 4));
        n = int'($urandom_range(1, 4));
        p = int'($urandom_range(1, 4));
      end
      nb = (sel == 9) ? (n % MAX_DIM) + 1 : n;
      program_dims(raw_dim(m), raw_dim(n), raw_dim(nb), raw_dim(p));

      // every entry the compute reads is loaded at least once; most get new values
      loads.delete();
      if (nb == n) begin
        for (int i = 0; i < m; i++)
          for (int k = 0; k < n; k++)
            if (!a_set[i][k] || $urandom_range(0, 3) != 0)
              loads.push_back(mk_word(CMD_LOAD_A, i, k, rand_element()));
        for (int k = 0; k < n; k++)
          for (int j = 0; j < p; j++)
            if (!b_set[k][j] || $urandom_range(0, 3) != 0)
              loads.push_back(mk_word(CMD_LOAD_B, k, j, rand_element()));
      end
      // stray loads anywhere and unused commands
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0)
          loads.push_back(mk_word(CMD_UNUSED, int'($urandom_range(0, 7)),
                                  int'($urandom_range(0, 7)), ELEM_WIDTH'($urandom)));
        else
          loads.push_back(mk_word(($urandom_range(0, 1) == 0) ? CMD_LOAD_A : CMD_LOAD_B,
                                  int'($urandom_range(0, 7)), int'($urandom_range(0, 7)),
                                  rand_element()));
      end
      for (int x = loads.size() - 1; x > 0; x--) begin
        pick        = int'($urandom_range(0, x));
        tmp         = loads[x];
        loads[x]    = loads[pick];
        loads[pick] = tmp;
      end

      foreach (loads[x]) begin
        send_word(loads[x]);
        if (loads[x].cmd != CMD_UNUSED) random_words++;
      end
      send_word(compute_word());
      random_words++;
      // second compute right behind the first has to wait out busy
      if ($urandom_range(0, 4) == 0) begin
        send_word(compute_word());
        random_words++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // result checker: each strobed word against the oldest expected element
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (c_pending.size() == 0) begin
        $error("unexpected result word: row %0d col %0d product %0d",
               out_word.out_row, out_word.out_col, out_word.product);
        errors++;
      end else begin
        want = c_pending.pop_front();
        results_checked++;
        if (want.mismatch) mismatch_words++;
        if (out_word.product !== want.product) begin
          $error("product: expected %0d, got %0d", want.product, out_word.product);
          errors++;
        end
        if (out_word.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_word.out_row);
          errors++;
        end
        if (out_word.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_word.out_col);
          errors++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_word.last);
          errors++;
        end
        if (out_word.mismatch !== want.mismatch) begin
          $error("mismatch: expected %0b, got %0b", want.mismatch, out_word.mismatch);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles where no word moves in either direction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // reset, then the test sequence
  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_A_ROWS;
    cfg_data   <= '0;
    reg_a_rows = DIM_RESET;
    reg_a_cols = DIM_RESET;
    reg_b_rows = DIM_RESET;
    reg_b_cols = DIM_RESET;
    errors          = 0;
    words_sent      = 0;
    computes_sent   = 0;
    random_words    = 0;
    results_checked = 0;
    mismatch_words  = 0;
    no_gaps         = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_saturation();
    test_dim_clamp();
    test_mismatch_and_unused();
    test_random_jobs();
    settle();

    $display("tb: %0d command words accepted, %0d of them compute, %0d in random jobs",
             words_sent, computes_sent, random_words);
    $display("tb: %0d result words checked, %0d dimension mismatch words among them",
             results_checked, mismatch_words);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
